// ===== design/csvg_pkg.sv =====
// Shared types, constants and tables of the cylinder side vertex generator.
package csvg_pkg;

  // Largest segment count the datapath is sized for.
  localparam int MAX_SEGMENTS  = 128;
  localparam int MIN_SEGMENTS  = 3;
  localparam int NW            = 8;   // segment count and angle step width
  localparam int IW            = 7;   // segment index width
  localparam int DW            = 24;  // dividend width
  localparam int QW            = 17;  // quotient width
  localparam int DIV_STAGES    = QW;
  localparam int CORDIC_STAGES = 16;
  localparam int XW            = 32;  // CORDIC vector width
  localparam int ZW            = 20;  // CORDIC angle width
  localparam int RW            = 15;  // radius and height width

  localparam logic [QW-1:0]        HALF_PI_Q16     = QW'(102944);
  localparam logic signed [XW-1:0] CORDIC_GAIN_Q28 = XW'(163008219);
  localparam logic signed [15:0]   ONE_Q14         = 16'sd16384;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_SEGMENTS = 2'd2;

  // Item moving through the divider cells.
  typedef struct packed {
    logic          vld;
    logic          second;
    logic [1:0]    quad;
    logic          rzero;
    logic [NW-1:0] n;
    logic [DW-1:0] dth;
    logic [DW-1:0] du;
    logic [NW-1:0] rth;
    logic [NW-1:0] ru;
    logic [QW-1:0] qth;
    logic [QW-1:0] qu;
  } div_tok_t;

  // Item moving through the CORDIC cells.
  typedef struct packed {
    logic                 vld;
    logic                 second;
    logic [1:0]           quad;
    logic                 rzero;
    logic [QW-1:0]        u;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cor_tok_t;

  // One finished ring vertex pair column (one angle).
  typedef struct packed {
    logic                 vld;
    logic                 second;
    logic signed [15:0]   cs;
    logic signed [15:0]   sn;
    logic signed [15:0]   px;
    logic signed [15:0]   pz;
    logic [QW-1:0]        u;
  } vert_t;

  // Arctangent of 2^-j in radians, 16 fraction bits.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] j);
    logic signed [ZW-1:0] a;
    case (j)
      4'd0:    a = ZW'(51472);
      4'd1:    a = ZW'(30386);
      4'd2:    a = ZW'(16055);
      4'd3:    a = ZW'(8150);
      4'd4:    a = ZW'(4091);
      4'd5:    a = ZW'(2047);
      4'd6:    a = ZW'(1024);
      4'd7:    a = ZW'(512);
      4'd8:    a = ZW'(256);
      4'd9:    a = ZW'(128);
      4'd10:   a = ZW'(64);
      4'd11:   a = ZW'(32);
      4'd12:   a = ZW'(16);
      4'd13:   a = ZW'(8);
      4'd14:   a = ZW'(4);
      default: a = ZW'(2);
    endcase
    return a;
  endfunction

  // Whether a slot of the six-vertex list uses the next angle.
  function automatic logic ring_next(input logic [2:0] slot);
    logic r;
    case (slot)
      3'd2, 3'd3, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  // Whether a slot of the six-vertex list lies on the bottom ring.
  function automatic logic ring_bottom(input logic [2:0] slot);
    logic r;
    case (slot)
      3'd0, 3'd2, 3'd3: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/csvg_div_cell.sv =====
// One restoring division cell: one quotient bit of angle and of u per item.
module csvg_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [4:0]          stage,
  input  csvg_pkg::div_tok_t  tok_in,
  output csvg_pkg::div_tok_t  tok_out
);

  csvg_pkg::div_tok_t tok_r, tok_nxt;
  logic [4:0]  bit_sel;
  logic [8:0]  rth_sh, ru_sh, n_ext;
  logic        th_ge, u_ge;

  // Bring down the next dividend bit and try one subtraction per quotient.
  always_comb begin
    bit_sel = 5'(csvg_pkg::DIV_STAGES - 1) - stage;
    n_ext   = {1'b0, tok_in.n};
    rth_sh  = {tok_in.rth, tok_in.dth[bit_sel]};
    ru_sh   = {tok_in.ru, tok_in.du[bit_sel]};
    th_ge   = (rth_sh >= n_ext);
    u_ge    = (ru_sh >= n_ext);
    tok_nxt = tok_in;
    tok_nxt.rth = th_ge ? 8'(rth_sh - n_ext) : rth_sh[7:0];
    tok_nxt.ru  = u_ge ? 8'(ru_sh - n_ext) : ru_sh[7:0];
    tok_nxt.qth = {tok_in.qth[csvg_pkg::QW-2:0], th_ge};
    tok_nxt.qu  = {tok_in.qu[csvg_pkg::QW-2:0], u_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r.vld <= tok_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r.second <= tok_nxt.second;
      tok_r.quad   <= tok_nxt.quad;
      tok_r.rzero  <= tok_nxt.rzero;
      tok_r.n      <= tok_nxt.n;
      tok_r.dth    <= tok_nxt.dth;
      tok_r.du     <= tok_nxt.du;
      tok_r.rth    <= tok_nxt.rth;
      tok_r.ru     <= tok_nxt.ru;
      tok_r.qth    <= tok_nxt.qth;
      tok_r.qu     <= tok_nxt.qu;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== design/csvg_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation per item.
module csvg_cordic_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [3:0]          stage,
  input  csvg_pkg::cor_tok_t  tok_in,
  output csvg_pkg::cor_tok_t  tok_out
);

  csvg_pkg::cor_tok_t tok_r, tok_nxt;
  logic signed [csvg_pkg::XW-1:0] dx, dy;
  logic signed [csvg_pkg::ZW-1:0] ang;

  // Rotate towards zero residual angle; arithmetic shifts round down.
  always_comb begin
    dx      = tok_in.y >>> stage;
    dy      = tok_in.x >>> stage;
    ang     = csvg_pkg::atan_q16(stage);
    tok_nxt = tok_in;
    if (!tok_in.z[csvg_pkg::ZW-1]) begin
      tok_nxt.x = tok_in.x - dx;
      tok_nxt.y = tok_in.y + dy;
      tok_nxt.z = tok_in.z - ang;
    end else begin
      tok_nxt.x = tok_in.x + dx;
      tok_nxt.y = tok_in.y - dy;
      tok_nxt.z = tok_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r.vld <= tok_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r.second <= tok_nxt.second;
      tok_r.quad   <= tok_nxt.quad;
      tok_r.rzero  <= tok_nxt.rzero;
      tok_r.u      <= tok_nxt.u;
      tok_r.x      <= tok_nxt.x;
      tok_r.y      <= tok_nxt.y;
      tok_r.z      <= tok_nxt.z;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== design/csvg_post.sv =====
// Rounds CORDIC results, applies the quadrant and scales by the radius.
module csvg_post (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [csvg_pkg::RW-1:0]       radius,
  input  csvg_pkg::cor_tok_t            tok_in,
  output csvg_pkg::vert_t               vert_out
);

  logic signed [17:0] xr, yr;
  logic signed [15:0] c, s, cs_nxt, sn_nxt;
  logic signed [15:0] cs_r, sn_r;
  logic [csvg_pkg::QW-1:0] u_r;
  logic vld_r, second_r;
  logic signed [31:0] mx, mz;
  csvg_pkg::vert_t vert_r;

  function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd16384) begin
      r = csvg_pkg::ONE_Q14;
    end else if (v < -18'sd16384) begin
      r = -csvg_pkg::ONE_Q14;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Round to 14 fraction bits, clamp and fold into the right quadrant.
  always_comb begin
    xr = 18'((tok_in.x + 32'sd8192) >>> 14);
    yr = 18'((tok_in.y + 32'sd8192) >>> 14);
    if (tok_in.rzero) begin
      c = csvg_pkg::ONE_Q14;
      s = 16'sd0;
    end else begin
      c = clamp_unit(xr);
      s = clamp_unit(yr);
    end
    case (tok_in.quad)
      2'd0:    begin cs_nxt = c;  sn_nxt = s;  end
      2'd1:    begin cs_nxt = -s; sn_nxt = c;  end
      2'd2:    begin cs_nxt = -c; sn_nxt = -s; end
      default: begin cs_nxt = s;  sn_nxt = -c; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      vert_r.vld <= 1'b0;
    end else if (en) begin
      vld_r      <= tok_in.vld;
      vert_r.vld <= vld_r;
    end
  end

  // Scale the unit vector by the radius in a second stage.
  always_comb begin
    mx = $signed({1'b0, radius}) * cs_r;
    mz = $signed({1'b0, radius}) * sn_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r          <= cs_nxt;
      sn_r          <= sn_nxt;
      u_r           <= tok_in.u;
      second_r      <= tok_in.second;
      vert_r.second <= second_r;
      vert_r.cs     <= cs_r;
      vert_r.sn     <= sn_r;
      vert_r.u      <= u_r;
      vert_r.px     <= 16'((mx + 32'sd8192) >>> 14);
      vert_r.pz     <= 16'((mz + 32'sd8192) >>> 14);
    end
  end

  assign vert_out = vert_r;

endmodule

// ===== design/csvg_emit.sv =====
// Pairs the two angles of a segment and sends its six vertices as items.
module csvg_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  csvg_pkg::vert_t           vert_in,
  output logic                      take,
  input  logic [csvg_pkg::RW-1:0]   height,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [103:0]              out_tdata,
  output logic                      out_tlast
);

  csvg_pkg::vert_t first_r;
  csvg_pkg::vert_t v0_r, v1_r, sel;
  logic            vld_r;
  logic [2:0]      slot_r;
  logic            free, bottom;
  logic [14:0]     half, py;

  // The emitter frees up as its sixth vertex is taken.
  assign free = !vld_r || (out_tready && (slot_r == 3'd5));
  assign take = vert_in.vld && (!vert_in.second || free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      slot_r <= 3'd0;
    end else begin
      if (vld_r && out_tready) begin
        slot_r <= 3'(slot_r + 3'd1);
        if (slot_r == 3'd5) begin
          vld_r <= 1'b0;
        end
      end
      if (take && vert_in.second) begin
        vld_r  <= 1'b1;
        slot_r <= 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !vert_in.second) begin
      first_r <= vert_in;
    end
    if (take && vert_in.second) begin
      v0_r <= first_r;
      v1_r <= vert_in;
    end
  end

  // Pick the angle and ring for the current slot.
  always_comb begin
    sel    = csvg_pkg::ring_next(slot_r) ? v1_r : v0_r;
    bottom = csvg_pkg::ring_bottom(slot_r);
    half   = {1'b0, height[14:1]};
    py     = bottom ? 15'(-half) : half;
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = (slot_r == 3'd5);
  assign out_tdata  = {4'd0, bottom, sel.u, sel.sn, sel.cs, sel.pz, py, sel.px, slot_r};

endmodule

// ===== design/cylinder_side_vertex_generator_core.sv =====
// Cylinder side vertex generator: one segment in, six vertices out (none for an index past the count).
// An accepted segment passes through the 17 divider cells, the 16 CORDIC cells,
// two post stages and the angle pair before its first vertex appears.
// Throughput is set by the six-vertex output channel; the front end accepts a
// segment, issues its two angles as the chain moves, then takes the next while earlier ones are in flight.
// Reset (synchronous, active low) empties all cells and restores the
// registers to radius 1.0, height 2.0 and 32 segments.
module cylinder_side_vertex_generator_core (
  input  logic          clk,
  input  logic          rst_n,
  // Configuration write port.
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [14:0]   cfg_wdata,
  // Input items.
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // segment_index[6:0], zero pad
  // Result items.
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,  // vertex_slot, pos_x, pos_y, pos_z, normal_x,
                                    // normal_z, tex_u, tex_v, zero pad
  output logic          out_tlast
);

  logic [csvg_pkg::RW-1:0] radius_r, height_r;
  logic [csvg_pkg::NW-1:0] segs_r, n_clamp, n_r, k_r;
  logic                    busy_r, second_r;
  logic                    adv, take;
  logic [9:0]              t, n1, n2, n3, n4, sub;
  logic [1:0]              quad;
  logic [csvg_pkg::NW-1:0] r;
  csvg_pkg::div_tok_t      front;
  csvg_pkg::div_tok_t      div_q [csvg_pkg::DIV_STAGES];
  csvg_pkg::cor_tok_t      cor_in;
  csvg_pkg::cor_tok_t      cor_q [csvg_pkg::CORDIC_STAGES];
  csvg_pkg::vert_t         vert;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 15'd256;
      height_r <= 15'd512;
      segs_r   <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        csvg_pkg::CFG_RADIUS:   radius_r <= cfg_wdata;
        csvg_pkg::CFG_HEIGHT:   height_r <= cfg_wdata;
        csvg_pkg::CFG_SEGMENTS: segs_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (segs_r < 8'(csvg_pkg::MIN_SEGMENTS)) begin
      n_clamp = 8'(csvg_pkg::MIN_SEGMENTS);
    end else if (segs_r > 8'(csvg_pkg::MAX_SEGMENTS)) begin
      n_clamp = 8'(csvg_pkg::MAX_SEGMENTS);
    end else begin
      n_clamp = segs_r;
    end
  end

  // The whole cell chain moves unless its tail cannot be handed on.
  assign adv       = !vert.vld || take;
  assign in_tready = !busy_r;

  // Issue the two angles of an accepted segment on successive moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      second_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      busy_r   <= ({1'b0, in_tdata[6:0]} < n_clamp);
      second_r <= 1'b0;
    end else if (busy_r && adv) begin
      busy_r   <= !second_r;
      second_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      k_r <= {1'b0, in_tdata[6:0]};
      n_r <= n_clamp;
    end else if (busy_r && adv && !second_r) begin
      k_r <= 8'(k_r + 8'd1);
    end
  end

  // Quadrant and remainder of 4k by N, then the two dividends.
  always_comb begin
    t  = {k_r, 2'b00};
    n1 = {2'b00, n_r};
    n2 = {1'b0, n_r, 1'b0};
    n3 = 10'(n1 + n2);
    n4 = {n_r, 2'b00};
    if (t >= n4) begin
      quad = 2'd0; sub = n4;
    end else if (t >= n3) begin
      quad = 2'd3; sub = n3;
    end else if (t >= n2) begin
      quad = 2'd2; sub = n2;
    end else if (t >= n1) begin
      quad = 2'd1; sub = n1;
    end else begin
      quad = 2'd0; sub = 10'd0;
    end
    r = 8'(t - sub);
    front.vld    = busy_r;
    front.second = second_r;
    front.quad   = quad;
    front.rzero  = (r == 8'd0);
    front.n      = n_r;
    front.dth    = 24'(r) * 24'(csvg_pkg::HALF_PI_Q16) + 24'(n_r >> 1);
    front.du     = {k_r, 16'd0} + 24'(n_r >> 1);
    front.rth    = {1'b0, front.dth[23:17]};
    front.ru     = {1'b0, front.du[23:17]};
    front.qth    = '0;
    front.qu     = '0;
  end

  // Divider chain.
  for (genvar j = 0; j < csvg_pkg::DIV_STAGES; j++) begin : g_div
    csvg_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .stage   (5'(j)),
      .tok_in  ((j == 0) ? front : div_q[(j == 0) ? 0 : j - 1]),
      .tok_out (div_q[j])
    );
  end

  // Start vector of the rotation.
  always_comb begin
    cor_in.vld    = div_q[csvg_pkg::DIV_STAGES-1].vld;
    cor_in.second = div_q[csvg_pkg::DIV_STAGES-1].second;
    cor_in.quad   = div_q[csvg_pkg::DIV_STAGES-1].quad;
    cor_in.rzero  = div_q[csvg_pkg::DIV_STAGES-1].rzero;
    cor_in.u      = div_q[csvg_pkg::DIV_STAGES-1].qu;
    cor_in.x      = csvg_pkg::CORDIC_GAIN_Q28;
    cor_in.y      = '0;
    cor_in.z      = $signed({3'b000, div_q[csvg_pkg::DIV_STAGES-1].qth});
  end

  // CORDIC chain.
  for (genvar j = 0; j < csvg_pkg::CORDIC_STAGES; j++) begin : g_cor
    csvg_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .stage   (4'(j)),
      .tok_in  ((j == 0) ? cor_in : cor_q[(j == 0) ? 0 : j - 1]),
      .tok_out (cor_q[j])
    );
  end

  csvg_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .radius   (radius_r),
    .tok_in   (cor_q[csvg_pkg::CORDIC_STAGES-1]),
    .vert_out (vert)
  );

  csvg_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .vert_in    (vert),
    .take       (take),
    .height     (height_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the cylinder side vertex generator core.
module tb_top;

  localparam int HOLD_LIMIT = 3000;  // cycles without any transfer before giving up
  localparam int DRAIN_WAIT = 80;    // longer than a segment's trip through the pipeline

  // One vertex as it leaves the block.
  typedef struct packed {
    logic [2:0]         slot;
    logic signed [15:0] px;
    logic signed [14:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] nz;
    logic [16:0]        u;
    logic               v;
    logic               last;
  } vertex_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = csvg_pkg::CFG_RADIUS;
  logic [14:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tlast;

  // Shadow copy of the configuration registers.
  logic [14:0]  radius_q = 15'd256;
  logic [14:0]  height_q = 15'd512;
  logic [7:0]   segments_q = 8'd32;

  vertex_t      vertex_q[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           hold_cycles = 0;
  bit           steady = 1'b0;

  always #5 clk = ~clk;

  cylinder_side_vertex_generator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // Floor shift of a signed value.
  function automatic longint sra(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_one(input longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // Cosine and sine of angle k/n of a full turn, Q1.14, by a 16-step CORDIC.
  task automatic angle_trig(input int k, input int n, output longint cs, output longint sn);
    longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    int t, q, r;
    longint c, s, x, y, z, dx, dy;
    t = 4 * k;
    q = (t / n) & 3;
    r = t % n;
    c = 16384;
    s = 0;
    if (r != 0) begin
      x = 163008219;
      y = 0;
      z = (longint'(r) * 102944 + n / 2) / n;
      for (int j = 0; j < 16; j++) begin
        dx = sra(y, j);
        dy = sra(x, j);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[j];
        end else begin
          x += dx; y -= dy; z += atan_tab[j];
        end
      end
      c = clamp_one(sra(x + 8192, 14));
      s = clamp_one(sra(y + 8192, 14));
    end
    case (q)
      0: begin cs = c;  sn = s;  end
      1: begin cs = -s; sn = c;  end
      2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endtask

  // Queue the six vertices a segment produces; indexes past the count give none.
  task automatic predict_segment(input int idx);
    longint cs[2], sn[2], px[2], pz[2], u[2];
    int n, w;
    bit bottom;
    longint half;
    vertex_t vx;
    n = segments_q;
    if (n < csvg_pkg::MIN_SEGMENTS) n = csvg_pkg::MIN_SEGMENTS;
    if (n > csvg_pkg::MAX_SEGMENTS) n = csvg_pkg::MAX_SEGMENTS;
    if (idx >= n) return;
    half = height_q >> 1;
    for (int e = 0; e < 2; e++) begin
      angle_trig(idx + e, n, cs[e], sn[e]);
      px[e] = sra(longint'(radius_q) * cs[e] + 8192, 14);
      pz[e] = sra(longint'(radius_q) * sn[e] + 8192, 14);
      u[e] = (longint'(idx + e) * 65536 + n / 2) / n;
    end
    for (int sl = 0; sl < 6; sl++) begin
      w = (sl == 2 || sl == 3 || sl == 5);
      bottom = (sl == 0 || sl == 2 || sl == 3);
      vx.slot = 3'(sl);
      vx.px = 16'(px[w]);
      vx.py = bottom ? 15'(-half) : 15'(half);
      vx.pz = 16'(pz[w]);
      vx.nx = 16'(cs[w]);
      vx.nz = 16'(sn[w]);
      vx.u = 17'(u[w]);
      vx.v = bottom;
      vx.last = (sl == 5);
      vertex_q.push_back(vx);
    end
  endtask

  // Offer one segment, with a random gap first unless in a steady stretch.
  task automatic send_segment(input int idx);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 30) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {1'b0, 7'(idx)};
    do @(posedge clk); while (!in_tready);
    predict_segment(idx);
  endtask

  // Drop valid and wait until every vertex has arrived and the pipe is empty.
  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (vertex_q.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input int val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = 15'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    case (addr)
      csvg_pkg::CFG_RADIUS: radius_q = 15'(val);
      csvg_pkg::CFG_HEIGHT: height_q = 15'(val);
      default:              segments_q = 8'(val);
    endcase
  endtask

  task automatic configure(input int rad, input int hgt, input int segs);
    write_reg(csvg_pkg::CFG_RADIUS, rad);
    write_reg(csvg_pkg::CFG_HEIGHT, hgt);
    write_reg(csvg_pkg::CFG_SEGMENTS, segs);
  endtask

  // Corners: reset settings, zero and full sizes, clamped and odd counts.
  task automatic test_directed;
    send_segment(0);
    send_segment(31);
    send_segment(32);
    drain();
    configure(0, 0, 3);
    for (int i = 0; i < 4; i++) send_segment(i);
    drain();
    configure(32767, 32767, 128);
    send_segment(0);
    send_segment(127);
    send_segment(64);
    send_segment(85);
    drain();
    configure(25600, 25600, 0);
    send_segment(2);
    send_segment(3);
    drain();
    configure(1, 1, 255);
    send_segment(127);
    send_segment(42);
    drain();
    configure(12345, 777, 5);
    for (int i = 0; i < 6; i++) send_segment(i);
    drain();
  endtask

  // Receiver holds off for a long stretch while segments keep coming.
  task automatic test_backpressure;
    configure(20000, 3000, 7);
    hold_cycles = 400;
    for (int i = 0; i < 25; i++) send_segment($urandom_range(6));
    drain();
  endtask

  // Random settings per phase; mostly valid indexes, some out of range.
  task automatic test_random;
    int n;
    for (int ph = 0; ph < 5; ph++) begin
      configure($urandom_range(32767), $urandom_range(32767), $urandom_range(255));
      n = segments_q < 3 ? 3 : (segments_q > 128 ? 128 : segments_q);
      steady = (ph == 2);
      for (int i = 0; i < 52; i++) begin
        if ($urandom_range(9) == 0) send_segment($urandom_range(127));
        else send_segment($urandom_range(n - 1));
      end
      steady = 1'b0;
      drain();
    end
  endtask

  // Receiver ready: random stalls, long hold-offs, or always ready when steady.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Compare each vertex with the oldest expectation.
  always @(posedge clk) begin
    vertex_t ex, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot = out_tdata[2:0];
      got.px   = out_tdata[18:3];
      got.py   = out_tdata[33:19];
      got.pz   = out_tdata[49:34];
      got.nx   = out_tdata[65:50];
      got.nz   = out_tdata[81:66];
      got.u    = out_tdata[98:82];
      got.v    = out_tdata[99];
      got.last = out_tlast;
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected vertex slot %0d", got.slot);
      end else begin
        ex = vertex_q.pop_front();
        if (got != ex) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Vertex mismatch: exp slot %0d p %0d %0d %0d n %0d %0d ",
                      "uv %0d %0d l %0d, got slot %0d p %0d %0d %0d n %0d %0d ",
                      "uv %0d %0d l %0d"},
                     ex.slot, ex.px, ex.py, ex.pz, ex.nx, ex.nz, ex.u, ex.v, ex.last,
                     got.slot, got.px, got.py, got.pz, got.nx, got.nz, got.u, got.v,
                     got.last);
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HOLD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    if (mismatches == 0 && vertex_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
